// ===== rtl/core/hsvr_pkg.sv =====
// hsvr_pkg: shared types, constants and scaling functions for the rainbow hsv to rgb block
// no dependencies; imported by every module of the block
`default_nettype none

package hsvr_pkg;

  // wheel constants
  localparam logic [7:0] K255       = 8'd255;
  localparam logic [7:0] K171       = 8'd171;
  localparam logic [7:0] K170       = 8'd170;
  localparam logic [7:0] K85        = 8'd85;
  localparam logic [7:0] ONE_THIRD  = 8'(256 / 3);
  localparam logic [7:0] TWO_THIRDS = 8'((256 * 2) / 3);
  localparam logic [4:0] RAMP_MASK  = 5'h1F;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_STRONG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HALVE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SCALE   = 2'd2;

  // hue wheel sections, picked by hue bits 7..5
  typedef enum logic [2:0] {
    SEC_RED_ORANGE,
    SEC_ORANGE_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_AQUA,
    SEC_AQUA_BLUE,
    SEC_BLUE_PURPLE,
    SEC_PURPLE_PINK,
    SEC_PINK_RED
  } sect_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic       yellow_strong;
    logic       green_halve;
    logic [7:0] green_scale;
  } cfg_t;

  // request between front and back: wheel color plus saturation and brightness terms
  typedef struct packed {
    rgb_t       color;
    logic [7:0] desat;
    logic       sat_full;
    logic       sat_zero;
    logic [7:0] vfac;
    logic       val_full;
  } mid_t;

  // (x * (s + 1)) >> 8
  function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] s);
    logic [16:0] p;
    p = {9'd0, x} * {8'd0, ({1'b0, s} + 9'd1)};
    return p[15:8];
  endfunction

  // ((x * s) >> 8) + 1 when both nonzero, wrapping at 8 bits
  function automatic logic [7:0] vscale8(input logic [7:0] x, input logic [7:0] s);
    logic [15:0] p;
    p = {8'd0, x} * {8'd0, s};
    return p[15:8] + (((x != 8'd0) && (s != 8'd0)) ? 8'd1 : 8'd0);
  endfunction

  // nonzero channel becomes scale + 1, zero stays zero
  function automatic logic [7:0] scale_nz(input logic [7:0] c, input logic [7:0] s);
    return (c == 8'd0) ? 8'd0 : (scale8(c, s) + 8'd1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsvr_front.sv =====
// hsvr_front: two-stage front end, hue wheel and green adjust plus saturation/brightness terms
// depends on hsvr_pkg
`default_nettype none

module hsvr_front
  import hsvr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire hsv_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output mid_t      out_data
);

  logic       s1_v_r, s2_v_r;
  mid_t       s1_r, s2_r;
  mid_t       s1_nxt, s2_nxt;
  logic       s1_ready, s2_ready;
  logic [7:0] ramp, third, twoth;
  logic [7:0] wr, wg, wb;
  logic [7:0] nsat;

  // stall control, each stage moves when the next has room
  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // ramp and its fractions
  assign ramp  = {in_data.hue[4:0] & RAMP_MASK, 3'b000};
  assign third = scale8(ramp, ONE_THIRD);
  assign twoth = scale8(ramp, TWO_THIRDS);
  assign nsat  = ~in_data.saturation;

  // eight-section rainbow wheel
  always_comb begin
    wr = 8'd0;
    wg = 8'd0;
    wb = 8'd0;
    case (sect_t'(in_data.hue[7:5]))
      SEC_RED_ORANGE: begin
        wr = K255 - third;
        wg = third;
      end
      SEC_ORANGE_YELLOW: begin
        if (cfg.yellow_strong) begin
          wr = K170 + third;
          wg = K85 + twoth;
        end else begin
          wr = K171;
          wg = K85 + third;
        end
      end
      SEC_YELLOW_GREEN: begin
        if (cfg.yellow_strong) begin
          wr = K255 - ramp;
          wg = K255;
        end else begin
          wr = K171 - twoth;
          wg = K170 + third;
        end
      end
      SEC_GREEN_AQUA: begin
        wg = K255 - third;
        wb = third;
      end
      SEC_AQUA_BLUE: begin
        wg = K171 - twoth;
        wb = K85 + twoth;
      end
      SEC_BLUE_PURPLE: begin
        wr = third;
        wb = K255 - third;
      end
      SEC_PURPLE_PINK: begin
        wr = K85 + third;
        wb = K171 - third;
      end
      default: begin
        wr = K170 + third;
        wb = K85 - third;
      end
    endcase
    if (cfg.green_halve) begin
      wg = {1'b0, wg[7:1]};
    end
  end

  // stage 1 contents
  always_comb begin
    s1_nxt.color.red   = wr;
    s1_nxt.color.green = wg;
    s1_nxt.color.blue  = wb;
    s1_nxt.desat       = vscale8(nsat, nsat);
    s1_nxt.sat_full    = (in_data.saturation == 8'd255);
    s1_nxt.sat_zero    = (in_data.saturation == 8'd0);
    s1_nxt.vfac        = scale8(in_data.brightness, in_data.brightness);
    s1_nxt.val_full    = (in_data.brightness == 8'd255);
  end

  // stage 2: optional green scaling
  always_comb begin
    s2_nxt = s1_r;
    if (cfg.green_scale != 8'd0) begin
      s2_nxt.color.green = scale8(s1_r.color.green, cfg.green_scale);
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

endmodule

`default_nettype wire

// ===== rtl/core/hsvr_queue.sv =====
// hsvr_queue: short queue of requests between front and back
// depends on hsvr_pkg
`default_nettype none

module hsvr_queue
  import hsvr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mid_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output mid_t      out_data
);

  mid_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           push, pop;

  assign in_ready  = (count_r != QCW'(QDEPTH));
  assign out_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsvr_back.sv =====
// hsvr_back: two-stage back end, saturation mix then brightness scaling into the output register
// depends on hsvr_pkg
`default_nettype none

module hsvr_back
  import hsvr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mid_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rgb_t      out_data
);

  logic       b1_v_r, b2_v_r;
  mid_t       b1_r, b1_nxt;
  rgb_t       b2_r, b2_nxt;
  logic       b1_ready, b2_ready;
  logic [7:0] ss;

  assign b2_ready = !b2_v_r || out_ready;
  assign b1_ready = !b1_v_r || b2_ready;
  assign in_ready = b1_ready;
  assign ss       = ~in_data.desat;

  // saturation: pass, white, or scale toward white plus desaturation floor
  always_comb begin
    b1_nxt = in_data;
    if (in_data.sat_zero) begin
      b1_nxt.color.red   = K255;
      b1_nxt.color.green = K255;
      b1_nxt.color.blue  = K255;
    end else if (!in_data.sat_full) begin
      b1_nxt.color.red   = scale_nz(in_data.color.red, ss) + in_data.desat;
      b1_nxt.color.green = scale_nz(in_data.color.green, ss) + in_data.desat;
      b1_nxt.color.blue  = scale_nz(in_data.color.blue, ss) + in_data.desat;
    end
  end

  // brightness: pass, black, or scale by squared value
  always_comb begin
    b2_nxt = b1_r.color;
    if (!b1_r.val_full) begin
      if (b1_r.vfac == 8'd0) begin
        b2_nxt = '0;
      end else begin
        b2_nxt.red   = scale_nz(b1_r.color.red, b1_r.vfac);
        b2_nxt.green = scale_nz(b1_r.color.green, b1_r.vfac);
        b2_nxt.blue  = scale_nz(b1_r.color.blue, b1_r.vfac);
      end
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_v_r <= in_valid;
      end
      if (b2_ready) begin
        b2_v_r <= b1_v_r;
      end
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (b1_ready && in_valid) begin
      b1_r <= b1_nxt;
    end
    if (b2_ready && b1_v_r) begin
      b2_r <= b2_nxt;
    end
  end

  assign out_valid = b2_v_r;
  assign out_data  = b2_r;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_rainbow_to_rgb.sv =====
// hsv_rainbow_to_rgb: top level, configuration registers, front end, queue and back end
// depends on hsvr_pkg, hsvr_front, hsvr_queue, hsvr_back
//
//   channel   ports                              payload
//   input     in_valid / in_ready / in_data       hsv_t: hue, saturation, brightness
//   result    out_valid / out_ready / out_data    rgb_t: red, green, blue
//   config    cfg_we / cfg_idx / cfg_wdata        yellow_strong, green_halve, green_scale
//
// one pixel per clock sustained while out_ready holds high; a pixel passes through five register stages
// (two front stages, one queue slot, two back stages incl. the output register), the first
// loaded at the accepting edge itself.
// rst_n is synchronous and clears all valid flags and the configuration registers.
// a stalled output only stops the back end; the two-entry queue lets the front keep
// accepting until it fills, then in_ready drops.
`default_nettype none

module hsv_rainbow_to_rgb
  import hsvr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hsv_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rgb_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [7:0]           cfg_wdata
);

  cfg_t cfg_r;
  logic f_valid, f_ready, q_valid, q_ready;
  mid_t f_data, q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_YELLOW_STRONG: cfg_r.yellow_strong <= cfg_wdata[0];
        CFG_GREEN_HALVE:   cfg_r.green_halve   <= cfg_wdata[0];
        CFG_GREEN_SCALE:   cfg_r.green_scale   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // wheel and per-pixel terms
  hsvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  // request queue
  hsvr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // saturation and brightness
  hsvr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/hsv_rainbow_to_rgb_test.sv =====
// self-checking testbench for hsv_rainbow_to_rgb: a directed table of pixels, then random pixels
// under several wheel settings, results checked against typed values or a local wheel predictor
// depends on hsvr_pkg and the hsv_rainbow_to_rgb top level
`timescale 1ns / 1ps

module hsv_rainbow_to_rgb_test;
  import hsvr_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 140;
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    hsv_t px;
    bit   typed;
    rgb_t want;
  } probe_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  hsv_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rgb_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [7:0]           cfg_wdata = '0;

  // predictor copy of the registers and the store of expected pixels
  cfg_t   wheel_cfg = '0;
  rgb_t   rgb_pending[$];
  probe_t probes[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     pixels_sent = 0;
  int     pixels_checked = 0;
  int     mismatches = 0;

  hsv_rainbow_to_rgb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // (x * (s + 1)) >> 8
  function automatic logic [7:0] frac_mul(input logic [7:0] x, input logic [7:0] s);
    logic [16:0] prod;
    prod = 17'(x) * (17'(s) + 17'd1);
    return prod[15:8];
  endfunction

  // zero stays zero, anything else is scaled and bumped by one
  function automatic logic [7:0] lift(input logic [7:0] c, input logic [7:0] s);
    return (c == 8'd0) ? 8'd0 : frac_mul(c, s) + 8'd1;
  endfunction

  // expected rgb for one pixel under the current wheel settings
  function automatic rgb_t rainbow_rgb(input hsv_t px);
    logic [7:0]  ramp, third, twoth, r, g, b, x, d, v;
    logic [15:0] sq;
    rgb_t        c;
    ramp  = {px.hue[4:0], 3'b000};
    third = frac_mul(ramp, ONE_THIRD);
    twoth = frac_mul(ramp, TWO_THIRDS);
    b     = 8'd0;
    g     = 8'd0;
    r     = 8'd0;
    // hue wheel
    case (sect_t'(px.hue[7:5]))
      SEC_RED_ORANGE: begin
        r = K255 - third; g = third;
      end
      SEC_ORANGE_YELLOW: begin
        if (wheel_cfg.yellow_strong) begin
          r = K170 + third; g = K85 + twoth;
        end else begin
          r = K171; g = K85 + third;
        end
      end
      SEC_YELLOW_GREEN: begin
        if (wheel_cfg.yellow_strong) begin
          r = K255 - ramp; g = K255;
        end else begin
          r = K171 - twoth; g = K170 + third;
        end
      end
      SEC_GREEN_AQUA: begin
        g = K255 - third; b = third;
      end
      SEC_AQUA_BLUE: begin
        g = K171 - twoth; b = K85 + twoth;
      end
      SEC_BLUE_PURPLE: begin
        r = third; b = K255 - third;
      end
      SEC_PURPLE_PINK: begin
        r = K85 + third; b = K171 - third;
      end
      default: begin
        r = K170 + third; b = K85 - third;
      end
    endcase
    // green shaping
    if (wheel_cfg.green_halve) g = g >> 1;
    if (wheel_cfg.green_scale != 8'd0) g = frac_mul(g, wheel_cfg.green_scale);
    // desaturation toward white, sums wrap at 8 bits
    if (px.saturation == 8'd0) begin
      r = 8'd255; g = 8'd255; b = 8'd255;
    end else if (px.saturation != 8'd255) begin
      x  = 8'd255 - px.saturation;
      sq = 16'(x) * 16'(x);
      d  = sq[15:8] + 8'd1;
      r  = lift(r, 8'd255 - d) + d;
      g  = lift(g, 8'd255 - d) + d;
      b  = lift(b, 8'd255 - d) + d;
    end
    // brightness by its own square
    if (px.brightness != 8'd255) begin
      v = frac_mul(px.brightness, px.brightness);
      r = (v == 8'd0) ? 8'd0 : lift(r, v);
      g = (v == 8'd0) ? 8'd0 : lift(g, v);
      b = (v == 8'd0) ? 8'd0 : lift(b, v);
    end
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  // random byte leaning toward the edges and the wrap region near full saturation
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 16));
      3: return 8'($urandom_range(240, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cfg_t make_cfg(input logic ys, input logic gh, input logic [7:0] gs);
    cfg_t c;
    c.yellow_strong = ys;
    c.green_halve   = gh;
    c.green_scale   = gs;
    return c;
  endfunction

  task automatic add_probe(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                           input bit typed, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    probe_t pr;
    pr.px.hue        = h;
    pr.px.saturation = s;
    pr.px.brightness = v;
    pr.typed         = typed;
    pr.want.red      = r;
    pr.want.green    = g;
    pr.want.blue     = b;
    probes.push_back(pr);
  endtask

  // one request on the input channel, with random idle cycles ahead of it
  task automatic send_pixel(input hsv_t px, input rgb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rgb_pending.push_back(want);
    pixels_sent++;
  endtask

  // hold the sender until every expected pixel is back, then let the pipe settle
  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rgb_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers, unused upper bits random, plus one write to the unused index
  task automatic load_settings(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_YELLOW_STRONG;
    cfg_wdata <= {7'($urandom), c.yellow_strong};
    @(posedge clk);
    cfg_idx   <= CFG_GREEN_HALVE;
    cfg_wdata <= {7'($urandom), c.green_halve};
    @(posedge clk);
    cfg_idx   <= CFG_GREEN_SCALE;
    cfg_wdata <= c.green_scale;
    @(posedge clk);
    cfg_idx   <= CFG_UNUSED_IDX;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    wheel_cfg = c;
  endtask

  // result side: random stalls and comparison against the oldest expected pixel
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rgb_pending.size() == 0) begin
        $display("%0t: result with nothing expected, got r=%0d g=%0d b=%0d",
                 $time, out_data.red, out_data.green, out_data.blue);
        mismatches++;
      end else begin
        want = rgb_pending.pop_front();
        pixels_checked++;
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue) begin
          $display("%0t: mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue,
                   out_data.red, out_data.green, out_data.blue);
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // main sequence
  initial begin
    cfg_t plan [PHASES];
    hsv_t px;
    plan[0]  = make_cfg(1'b0, 1'b0, 8'd0);
    plan[1]  = make_cfg(1'b1, 1'b0, 8'd0);
    plan[2]  = make_cfg(1'b0, 1'b1, 8'd0);
    plan[3]  = make_cfg(1'b0, 1'b0, 8'd255);
    plan[4]  = make_cfg(1'b1, 1'b1, 8'd1);
    plan[5]  = make_cfg(1'b0, 1'b0, 8'd1);
    plan[6]  = make_cfg(1'b1, 1'b0, 8'd128);
    plan[7]  = make_cfg(1'b0, 1'b1, 8'd255);
    plan[8]  = make_cfg(1'b1, 1'b1, 8'($urandom_range(2, 254)));
    plan[9]  = make_cfg(1'($urandom), 1'($urandom), 8'($urandom));
    plan[10] = make_cfg(1'b0, 1'b0, 8'd0);

    // primary colors, section starts, white, black and the brightness floor
    add_probe(8'd0,   8'd255, 8'd255, 1, 8'd255, 8'd0,   8'd0);
    add_probe(8'd0,   8'd0,   8'd255, 1, 8'd255, 8'd255, 8'd255);
    add_probe(8'd0,   8'd255, 8'd0,   1, 8'd0,   8'd0,   8'd0);
    add_probe(8'd255, 8'd0,   8'd0,   1, 8'd0,   8'd0,   8'd0);
    add_probe(8'd0,   8'd255, 8'd1,   1, 8'd0,   8'd0,   8'd0);
    add_probe(8'd32,  8'd255, 8'd255, 1, 8'd171, 8'd85,  8'd0);
    add_probe(8'd64,  8'd255, 8'd255, 1, 8'd171, 8'd170, 8'd0);
    add_probe(8'd96,  8'd255, 8'd255, 1, 8'd0,   8'd255, 8'd0);
    add_probe(8'd128, 8'd255, 8'd255, 1, 8'd0,   8'd171, 8'd85);
    add_probe(8'd160, 8'd255, 8'd255, 1, 8'd0,   8'd0,   8'd255);
    add_probe(8'd192, 8'd255, 8'd255, 1, 8'd85,  8'd0,   8'd171);
    add_probe(8'd224, 8'd255, 8'd255, 1, 8'd170, 8'd0,   8'd85);
    // end of ramp, wrap near full saturation, faint saturation, dim pixels
    add_probe(8'd31,  8'd255, 8'd255, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd255, 8'd255, 8'd255, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd0,   8'd254, 8'd255, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd170, 8'd240, 8'd255, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd0,   8'd1,   8'd255, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd85,  8'd15,  8'd255, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd100, 8'd128, 8'd254, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd200, 8'd255, 8'd16,  0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd200, 8'd255, 8'd15,  0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd63,  8'd0,   8'd128, 0, 8'd0, 8'd0, 8'd0);
    add_probe(8'd127, 8'd200, 8'd200, 0, 8'd0, 8'd0, 8'd0);

    send_idle_pct = 33;
    recv_idle_pct = 86;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under reset settings
    foreach (probes[i]) begin
      send_pixel(probes[i].px,
                 probes[i].typed ? probes[i].want : rainbow_rgb(probes[i].px));
    end

    // random pixels, one batch per register setting
    for (int p = 0; p < PHASES; p++) begin
      pause_sender();
      if (p >= 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (p >= 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 33;
      end
      if (p != 0) load_settings(plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) pause_sender();
        px.hue        = pick_byte();
        px.saturation = pick_byte();
        px.brightness = pick_byte();
        send_pixel(px, rainbow_rgb(px));
      end
    end
    pause_sender();

    $display("covered %0d pixels over %0d register settings and three stall mixes",
             pixels_sent, PHASES);
    $display("%0d results compared, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0 && rgb_pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout, %0d results still outstanding", rgb_pending.size());
    $display("FAIL");
    $finish;
  end

endmodule
